### hw/rtl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_engine: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_engine: next-cycle check failed");
`else
`define PLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, operation and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 7;
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CK_HOLD = 2'd0;
  localparam logic [1:0] CK_INS  = 2'd1;
  localparam logic [1:0] CK_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              rd_en;
  } cell_cmd_t;

endpackage

### hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words with read, insert and delete by position.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (operation, position, value) and every
// request yields exactly one beat on the out_ channel (read_value, status,
// length). Both channels use valid/ready handshakes.
// The list lives in a row of cells, one entry per cell; an insert or delete
// shifts every later cell by one place at once.
// A request passes through capture, execution in the cell row, and
// gather of the read data through a registered OR tree. The block takes
// one request at a time and accepts no new one until the last has left
// the gather step. The output register lets the next request be
// captured while a result beat still waits for out_ready; a stalled
// receiver keeps the finished request in gather and then blocks new input.
// Reset empties the list (length zero) and drops any pending result; the
// cell contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module positional_list_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ple_pkg::OP_W-1:0]       in_operation,
  input  logic signed [ple_pkg::POS_W-1:0]  in_position,
  input  logic signed [ple_pkg::WORD_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ple_pkg::WORD_W-1:0] out_read_value,
  output logic [ple_pkg::ST_W-1:0]       out_status,
  output logic [ple_pkg::LEN_W-1:0]      out_length
);
  import ple_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_GATHER = 2'd2;

  localparam logic [CNT_W-1:0] CAP_LEN = CNT_W'(CAPACITY);

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              is_read_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_rd_r;
  logic [ST_W-1:0]   out_st_r;
  logic [CNT_W-1:0]  out_len_r;

  cell_cmd_t         cmd;
  logic [CAPACITY-1:0][WORD_W-1:0] cell_vals;
  logic [CAPACITY-1:0][WORD_W-1:0] rd_parts;
  logic [WORD_W-1:0] gathered;

  logic              in_fire;
  logic              load_out;
  logic              pos_neg;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              in_list;
  logic              full;
  logic              exec;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exec     = (state_r == S_EXEC);
  assign load_out = (state_r == S_GATHER) && (!out_valid_r || out_ready);

  assign pos_neg = pos_r[POS_W-1];
  assign pos_ext = CMP_W'(pos_r[POS_W-2:0]);
  assign cnt_ext = CMP_W'(count_r);
  assign in_list = !pos_neg && (pos_ext < cnt_ext);
  assign full    = (count_r == CNT_W'(CAPACITY));

  // Decode the captured request into a cell command and its result.
  always_comb begin
    logic [CMP_W-1:0] ins_p;
    logic             is_ins;
    ins_p      = '0;
    is_ins     = 1'b0;
    cmd.kind   = CK_HOLD;
    cmd.idx    = pos_r[IDX_W-1:0];
    cmd.word   = word_r;
    cmd.rd_en  = 1'b0;
    count_nxt  = count_r;
    res_st_nxt = ST_DONE;
    rd_ok_nxt  = 1'b0;
    unique case (op_r)
      OP_READ: begin
        rd_ok_nxt  = in_list;
        cmd.rd_en  = exec && in_list;
        res_st_nxt = in_list ? ST_DONE : ST_RANGE;
      end
      OP_HEAD: begin
        is_ins = 1'b1;
        ins_p  = '0;
      end
      OP_TAIL: begin
        is_ins = 1'b1;
        ins_p  = cnt_ext;
      end
      OP_AT: begin
        is_ins = 1'b1;
        ins_p  = pos_neg ? '0 : pos_ext;
      end
      OP_DELETE: begin
        if (in_list) begin
          cmd.kind  = exec ? CK_DEL : CK_HOLD;
          count_nxt = count_r - 1'b1;
        end else begin
          res_st_nxt = ST_RANGE;
        end
      end
      default: res_st_nxt = ST_RANGE;
    endcase
    if (is_ins) begin
      cmd.idx = ins_p[IDX_W-1:0];
      if (ins_p > cnt_ext) begin
        res_st_nxt = ST_RANGE;
      end else if (full) begin
        res_st_nxt = ST_FULL;
      end else begin
        cmd.kind  = exec ? CK_INS : CK_HOLD;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_GATHER;
      S_GATHER: if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        count_r <= count_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      word_r <= in_value;
    end
    if (exec) begin
      res_st_r  <= res_st_nxt;
      rd_ok_r   <= rd_ok_nxt;
      is_read_r <= (op_r == OP_READ);
    end
    if (load_out) begin
      out_st_r  <= res_st_r;
      out_len_r <= count_r;
      if (!is_read_r) begin
        out_rd_r <= '0;
      end else if (rd_ok_r) begin
        out_rd_r <= gathered;
      end else begin
        out_rd_r <= '1;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ple_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .left_val  ((g == 0) ? word_r : cell_vals[(g == 0) ? 0 : g - 1]),
      .right_val (cell_vals[(g == CAPACITY - 1) ? g : g + 1]),
      .entry_val (cell_vals[g]),
      .rd_part   (rd_parts[g])
    );
  end

  ple_gather u_gather (
    .clk   (clk),
    .en    (exec),
    .parts (rd_parts),
    .word  (gathered)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_st_r;
  assign out_length     = LEN_W'(out_len_r);

  `PLE_ASSERT_IMP(a_len_bound, clk, rst_n, out_valid, out_len_r <= CAP_LEN)
  `PLE_ASSERT_IMP(a_full_len, clk, rst_n, out_valid && out_status == ST_FULL, out_len_r == CAP_LEN)
  `PLE_ASSERT_NXT(a_fire_exec, clk, rst_n, in_fire, state_r == S_EXEC)
  `PLE_ASSERT_NXT(a_idle_count, clk, rst_n, !exec, $stable(count_r))

endmodule

### hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and shifts it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                          clk,
  input  logic [ple_pkg::IDX_W-1:0]     cell_idx,
  input  ple_pkg::cell_cmd_t            cmd,
  input  logic [ple_pkg::WORD_W-1:0]    left_val,
  input  logic [ple_pkg::WORD_W-1:0]    right_val,
  output logic [ple_pkg::WORD_W-1:0]    entry_val,
  output logic [ple_pkg::WORD_W-1:0]    rd_part
);
  import ple_pkg::*;

  logic [WORD_W-1:0] entry_r;
  logic [WORD_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.kind)
      CK_INS: begin
        if (cell_idx > cmd.idx) begin
          entry_nxt = left_val;
        end else if (cell_idx == cmd.idx) begin
          entry_nxt = cmd.word;
        end
      end
      CK_DEL: begin
        if (cell_idx >= cmd.idx) begin
          entry_nxt = right_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_val = entry_r;
  assign rd_part   = (cmd.rd_en && (cell_idx == cmd.idx)) ? entry_r : '0;

endmodule

### hw/rtl/ple_gather.sv
// ----------------------------------------------------------------------------
// Positional list engine read gather
// Registered OR tree that collects the one selected entry from the cells.
// ----------------------------------------------------------------------------
module ple_gather (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [ple_pkg::CAPACITY-1:0][ple_pkg::WORD_W-1:0] parts,
  output logic [ple_pkg::WORD_W-1:0]                    word
);
  import ple_pkg::*;

  logic [NGROUP-1:0][WORD_W-1:0] group_r;
  logic [NGROUP-1:0][WORD_W-1:0] group_nxt;

  // At most one cell drives a nonzero part, so OR acts as the selector.
  always_comb begin
    group_nxt = '0;
    for (int g = 0; g < NGROUP; g++) begin
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          group_nxt[g] = group_nxt[g] | parts[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      group_r <= group_nxt;
    end
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < NGROUP; g++) begin
      word = word | group_r[g];
    end
  end

endmodule
